### hw/rtl/prp3d_pkg.sv
// shared constants, types and sine/cosine tables of the point rotate and project unit
package prp3d_pkg;

   // angle codes and fixed point formats
   localparam int ANGLE_BITS     = 10;
   localparam int ANGLE_STEPS    = 1 << ANGLE_BITS;
   localparam int QUAD_BITS      = ANGLE_BITS - 2;
   localparam int QUAD_STEPS     = 1 << QUAD_BITS;
   localparam int TRIG_FRAC_BITS = 14;
   localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
   localparam int ROM_W          = TRIG_FRAC_BITS + 1;
   localparam int Q8_BITS        = 8;

   // field and register widths
   localparam int FIELD_W     = 16;
   localparam int SCREEN_W    = 24;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int ROT_W       = 3 * ANGLE_BITS;
   localparam int ISO_W       = ANGLE_BITS + 1;
   localparam int ISO_EN_BIT  = ANGLE_BITS;

   // datapath widths
   localparam int SCALE_W = 2 * FIELD_W + 1;
   localparam int HZ_W    = SCALE_W + FIELD_W;
   localparam int COORD_W = 45;
   localparam int PROD_W  = COORD_W + TRIG_W;
   localparam int SUM_W   = PROD_W + 1;

   // pipeline depth
   localparam int NUM_STAGES = 12;
   localparam int STAGE_W    = $clog2(NUM_STAGES + 1);

   // register reset values
   localparam logic [FIELD_W-1:0]        ZOOM_RESET   = FIELD_W'(256);
   localparam logic signed [FIELD_W-1:0] HSCALE_RESET = FIELD_W'(256);
   localparam logic [ISO_W-1:0]          ISO_RESET    =
      {1'b1, ANGLE_BITS'(ANGLE_STEPS / 2)};

   localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_FRAC_BITS);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ZOOM_FACTOR     = 4'd0,
      CSR_HEIGHT_SCALE    = 4'd1,
      CSR_CENTER_X        = 4'd2,
      CSR_CENTER_Y        = 4'd3,
      CSR_ROTATION_ANGLES = 4'd4,
      CSR_ISO_CONTROL     = 4'd5,
      CSR_SHIFT_X         = 4'd6,
      CSR_SHIFT_Y         = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sn;
      logic signed [TRIG_W-1:0] cs;
   } trig_type;

   typedef struct packed {
      logic mul_load;
      logic sum_load;
   } stage_en_type;

   typedef logic [ROM_W-1:0] trig_rom_type [QUAD_STEPS];

   // taylor series in q30, every term floored
   localparam int SERIES_TERMS = 7;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned SIN_DIV [SERIES_TERMS] = '{6, 20, 42, 72, 110, 156, 210};
   localparam longint unsigned COS_DIV [SERIES_TERMS] = '{2, 12, 30, 56, 90, 132, 182};

   function automatic longint series_value(input longint unsigned r, input bit want_cos);
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      int              i;
      x2   = (r * r) >> 30;
      term = want_cos ? (64'd1 << 30) : r;
      sum  = longint'(term);
      for (i = 0; i < SERIES_TERMS; i++) begin
         term = (term * x2) >> 30;
         term = want_cos ? term / COS_DIV[i] : term / SIN_DIV[i];
         sum  = i[0] ? sum + longint'(term) : sum - longint'(term);
      end
      return sum;
   endfunction

   function automatic logic [ROM_W-1:0] round_trig(input longint v);
      longint c;
      c = (v < 0) ? 64'sd0 : v;
      if (c > (64'sd1 <<< 30)) begin
         c = 64'sd1 <<< 30;
      end
      return ROM_W'((c + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS));
   endfunction

   // first quadrant table, index j stands for the angle code j
   function automatic trig_rom_type build_rom(input bit want_cos);
      trig_rom_type    rom;
      longint unsigned r;
      int              j;
      for (j = 0; j < QUAD_STEPS; j++) begin
         r      = HALF_PI_Q30 * longint'(4 * j) / ANGLE_STEPS;
         rom[j] = round_trig(series_value(r, want_cos));
      end
      return rom;
   endfunction

   localparam trig_rom_type SIN_ROM = build_rom(1'b0);
   localparam trig_rom_type COS_ROM = build_rom(1'b1);

endpackage

### hw/rtl/prp3d_if.sv
// valid/ready channel interfaces: point items, screen items and register writes

interface prp3d_req_if;
   import prp3d_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] grid_x;
   logic signed [FIELD_W-1:0] grid_y;
   logic signed [FIELD_W-1:0] height;

   modport source (output valid, output grid_x, output grid_y, output height, input ready);
   modport sink   (input valid, input grid_x, input grid_y, input height, output ready);
endinterface

interface prp3d_rsp_if;
   import prp3d_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SCREEN_W-1:0] screen_x;
   logic signed [SCREEN_W-1:0] screen_y;

   modport source (output valid, output screen_x, output screen_y, input ready);
   modport sink   (input valid, input screen_x, input screen_y, output ready);
endinterface

interface prp3d_csr_if;
   import prp3d_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/prp3d_trig.sv
// sine and cosine of one angle code from the first quadrant tables
module prp3d_trig (
   input  logic [prp3d_pkg::ANGLE_BITS-1:0] code,
   output prp3d_pkg::trig_type              value
);
   import prp3d_pkg::*;

   logic [QUAD_BITS-1:0]     idx;
   logic [1:0]               quad;
   logic signed [TRIG_W-1:0] s_pos;
   logic signed [TRIG_W-1:0] c_pos;

   assign quad  = code[ANGLE_BITS-1 -: 2];
   assign idx   = code[QUAD_BITS-1:0];
   assign s_pos = $signed({1'b0, SIN_ROM[idx]});
   assign c_pos = $signed({1'b0, COS_ROM[idx]});

   // quadrant fold
   always_comb begin
      unique case (quad)
         2'd0: begin
            value.sn = s_pos;
            value.cs = c_pos;
         end
         2'd1: begin
            value.sn = c_pos;
            value.cs = -s_pos;
         end
         2'd2: begin
            value.sn = -s_pos;
            value.cs = -c_pos;
         end
         default: begin
            value.sn = -c_pos;
            value.cs = s_pos;
         end
      endcase
   end

endmodule

### hw/rtl/prp3d_rot.sv
// one plane rotation over two stages: four products, then sum, difference and floor
module prp3d_rot (
   input  logic                                  clock,
   input  prp3d_pkg::stage_en_type               load,
   input  logic signed [prp3d_pkg::COORD_W-1:0]  coord_a,
   input  logic signed [prp3d_pkg::COORD_W-1:0]  coord_b,
   input  prp3d_pkg::trig_type                   trig,
   output logic signed [prp3d_pkg::COORD_W-1:0]  rot_a,
   output logic signed [prp3d_pkg::COORD_W-1:0]  rot_b
);
   import prp3d_pkg::*;

   logic signed [PROD_W-1:0]  ac_in, bs_in, as_in, bc_in;
   logic signed [PROD_W-1:0]  ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [SUM_W-1:0]   dif_in, add_in;
   logic signed [COORD_W-1:0] rot_a_ff, rot_b_ff;

   assign ac_in = coord_a * trig.cs;
   assign bs_in = coord_b * trig.sn;
   assign as_in = coord_a * trig.sn;
   assign bc_in = coord_b * trig.cs;

   // a' = a*cos - b*sin, b' = a*sin + b*cos
   assign dif_in = SUM_W'(ac_ff) - SUM_W'(bs_ff);
   assign add_in = SUM_W'(as_ff) + SUM_W'(bc_ff);

   always_ff @(posedge clock) begin
      if (load.mul_load) begin
         ac_ff <= ac_in;
         bs_ff <= bs_in;
         as_ff <= as_in;
         bc_ff <= bc_in;
      end
      if (load.sum_load) begin
         rot_a_ff <= dif_in[TRIG_FRAC_BITS +: COORD_W];
         rot_b_ff <= add_in[TRIG_FRAC_BITS +: COORD_W];
      end
   end

   assign rot_a = rot_a_ff;
   assign rot_b = rot_b_ff;

endmodule

### hw/rtl/point_rotate_project_3d_unit.sv
// top level of the point rotate and project unit
//
// req_bus carries one map point (grid_x, grid_y, height) per item, rsp_bus
// one screen position (screen_x, screen_y) per item, in the same order.
// csr_bus writes the eight setup registers (zoom, height scale, centers,
// rotation angles, iso control, screen shifts); write them only while no
// item is in flight. csr_bus is always ready, and req_bus is held off for
// the cycle in which a write is presented.
// throughput: one item per cycle while rsp_ready is high and no write is
// presented; items pass the 12-stage pipeline (scale, center and height
// multiply, three rotations of two stages each, three projection stages,
// floor and saturate).
// reset clears the stage valid bits and loads the register defaults; there
// is no clearing pass, the unit takes an item in the first cycle after reset.
// when rsp_ready is low the last stage holds its item and every stage in
// front keeps moving into the empty slots behind it, so req_ready stays high
// until all 12 stages hold an item.
module point_rotate_project_3d_unit (
   input logic         clock,
   input logic         reset,
   prp3d_csr_if.sink   csr_bus,
   prp3d_req_if.sink   req_bus,
   prp3d_rsp_if.source rsp_bus
);
   import prp3d_pkg::*;

   localparam logic signed [COORD_W-1:0] SCREEN_HI = COORD_W'((1 << (SCREEN_W - 1)) - 1);
   localparam logic signed [COORD_W-1:0] SCREEN_LO = COORD_W'(-(1 << (SCREEN_W - 1)));

   function automatic logic signed [SCREEN_W-1:0] to_screen(
      input logic signed [COORD_W-1:0] v
   );
      logic signed [SCREEN_W-1:0] r;
      if (v > SCREEN_HI) begin
         r = SCREEN_HI[SCREEN_W-1:0];
      end else if (v < SCREEN_LO) begin
         r = SCREEN_LO[SCREEN_W-1:0];
      end else begin
         r = v[SCREEN_W-1:0];
      end
      return r;
   endfunction

   // setup registers
   logic [FIELD_W-1:0]         zoom_factor_ff, zoom_factor_in;
   logic signed [FIELD_W-1:0]  height_scale_ff, height_scale_in;
   logic signed [FIELD_W-1:0]  center_x_ff, center_x_in;
   logic signed [FIELD_W-1:0]  center_y_ff, center_y_in;
   logic [ROT_W-1:0]           rotation_angles_ff, rotation_angles_in;
   logic [ISO_W-1:0]           iso_control_ff, iso_control_in;
   logic signed [SCREEN_W-1:0] shift_x_ff, shift_x_in;
   logic signed [SCREEN_W-1:0] shift_y_ff, shift_y_in;
   logic                       iso_en;

   // trig values, registered from the lookups on the angle registers
   trig_type trig_x, trig_y, trig_z, trig_iso;
   trig_type trig_x_ff, trig_y_ff, trig_z_ff, iso_trig_ff, iso_trig_in;

   // stage control
   logic [NUM_STAGES-1:0] vld_ff, vld_in, adv;
   logic                  req_accept;

   // stage payload
   logic signed [FIELD_W:0]    zoom_s;
   logic signed [SCALE_W-1:0]  px_in, py_in, ph_in, px_ff, py_ff, ph_ff;
   logic signed [COORD_W-1:0]  xb_in, yb_in, xb_ff, yb_ff;
   logic signed [HZ_W-1:0]     hz_in, hz_ff;
   logic signed [COORD_W-1:0]  z_s;
   logic signed [COORD_W-1:0]  xb_s2_ff, xb_s3_ff;
   logic signed [COORD_W-1:0]  y1, z1, x1, z2, x2, y2;
   logic signed [COORD_W-1:0]  y1_s4_ff, y1_s5_ff;
   logic signed [COORD_W-1:0]  z2_s6_ff, z2_s7_ff, z2_s8_ff, z2_s9_ff;
   logic signed [COORD_W-1:0]  dif_in, sum_in, dif_ff, sum_ff;
   logic signed [PROD_W-1:0]   pd_in, ps_in, pd_ff, ps_ff;
   logic signed [COORD_W-1:0]  z2_sel;
   logic signed [COORD_W-1:0]  qx_in, qy_in, qx_ff, qy_ff;
   logic signed [SCREEN_W-1:0] scr_x_in, scr_y_in, scr_x_ff, scr_y_ff;
   stage_en_type               rot_x_load, rot_y_load, rot_z_load;

   // ---------------------------------------------------------------
   // register writes
   // ---------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_comb begin
      zoom_factor_in     = zoom_factor_ff;
      height_scale_in    = height_scale_ff;
      center_x_in        = center_x_ff;
      center_y_in        = center_y_ff;
      rotation_angles_in = rotation_angles_ff;
      iso_control_in     = iso_control_ff;
      shift_x_in         = shift_x_ff;
      shift_y_in         = shift_y_ff;
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_ZOOM_FACTOR:     zoom_factor_in     = csr_bus.data[FIELD_W-1:0];
            CSR_HEIGHT_SCALE:    height_scale_in    = csr_bus.data[FIELD_W-1:0];
            CSR_CENTER_X:        center_x_in        = csr_bus.data[FIELD_W-1:0];
            CSR_CENTER_Y:        center_y_in        = csr_bus.data[FIELD_W-1:0];
            CSR_ROTATION_ANGLES: rotation_angles_in = csr_bus.data[ROT_W-1:0];
            CSR_ISO_CONTROL:     iso_control_in     = csr_bus.data[ISO_W-1:0];
            CSR_SHIFT_X:         shift_x_in         = csr_bus.data[SCREEN_W-1:0];
            CSR_SHIFT_Y:         shift_y_in         = csr_bus.data[SCREEN_W-1:0];
            default: ;  // index past the register list, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_factor_ff     <= ZOOM_RESET;
         height_scale_ff    <= HSCALE_RESET;
         center_x_ff        <= '0;
         center_y_ff        <= '0;
         rotation_angles_ff <= '0;
         iso_control_ff     <= ISO_RESET;
         shift_x_ff         <= '0;
         shift_y_ff         <= '0;
      end else begin
         zoom_factor_ff     <= zoom_factor_in;
         height_scale_ff    <= height_scale_in;
         center_x_ff        <= center_x_in;
         center_y_ff        <= center_y_in;
         rotation_angles_ff <= rotation_angles_in;
         iso_control_ff     <= iso_control_in;
         shift_x_ff         <= shift_x_in;
         shift_y_ff         <= shift_y_in;
      end
   end

   assign iso_en = iso_control_ff[ISO_EN_BIT];

   // ---------------------------------------------------------------
   // trig lookups
   // ---------------------------------------------------------------
   prp3d_trig u_trig_x (.code(rotation_angles_ff[0 +: ANGLE_BITS]),              .value(trig_x));
   prp3d_trig u_trig_y (.code(rotation_angles_ff[ANGLE_BITS +: ANGLE_BITS]),     .value(trig_y));
   prp3d_trig u_trig_z (.code(rotation_angles_ff[2 * ANGLE_BITS +: ANGLE_BITS]), .value(trig_z));
   prp3d_trig u_trig_i (.code(iso_control_ff[ANGLE_BITS-1:0]),                   .value(trig_iso));

   // with iso off the projection stages multiply by one and pass x, y through
   assign iso_trig_in = iso_en ? trig_iso : trig_type'{sn: TRIG_ONE, cs: TRIG_ONE};

   always_ff @(posedge clock) begin
      trig_x_ff   <= trig_x;
      trig_y_ff   <= trig_y;
      trig_z_ff   <= trig_z;
      iso_trig_ff <= iso_trig_in;
   end

   // ---------------------------------------------------------------
   // stage valid bits; a stage loads when any slot from it to the
   // output is empty or the output item leaves
   // ---------------------------------------------------------------
   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_adv
      assign adv[g] = rsp_bus.ready || !(&vld_ff[NUM_STAGES-1:g]);
   end

   // a pending register write goes ahead of the next item
   assign req_bus.ready = adv[0] && !csr_bus.valid;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      vld_in[0] = adv[0] ? req_accept : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------
   // datapath, all coordinates signed q.8 pixels
   // ---------------------------------------------------------------
   // stage 0: zoom
   assign zoom_s = $signed({1'b0, zoom_factor_ff});
   assign px_in  = req_bus.grid_x * zoom_s;
   assign py_in  = req_bus.grid_y * zoom_s;
   assign ph_in  = req_bus.height * zoom_s;

   // stage 1: centers, height scale
   assign xb_in = COORD_W'(px_ff) - (COORD_W'(center_x_ff) <<< Q8_BITS);
   assign yb_in = COORD_W'(py_ff) - (COORD_W'(center_y_ff) <<< Q8_BITS);
   assign hz_in = ph_ff * height_scale_ff;
   assign z_s   = COORD_W'(hz_ff >>> Q8_BITS);

   // stages 2-3: about x, (y, z) -> (y1, z1)
   assign rot_x_load = '{mul_load: adv[2], sum_load: adv[3]};
   prp3d_rot u_rot_x (
      .clock   (clock),
      .load    (rot_x_load),
      .coord_a (yb_ff),
      .coord_b (z_s),
      .trig    (trig_x_ff),
      .rot_a   (y1),
      .rot_b   (z1)
   );

   // stages 4-5: about y, (x, z1) -> (x1, z2)
   assign rot_y_load = '{mul_load: adv[4], sum_load: adv[5]};
   prp3d_rot u_rot_y (
      .clock   (clock),
      .load    (rot_y_load),
      .coord_a (xb_s3_ff),
      .coord_b (z1),
      .trig    (trig_y_ff),
      .rot_a   (x1),
      .rot_b   (z2)
   );

   // stages 6-7: about z, (x1, y1) -> (x2, y2)
   assign rot_z_load = '{mul_load: adv[6], sum_load: adv[7]};
   prp3d_rot u_rot_z (
      .clock   (clock),
      .load    (rot_z_load),
      .coord_a (x1),
      .coord_b (y1_s5_ff),
      .trig    (trig_z_ff),
      .rot_a   (x2),
      .rot_b   (y2)
   );

   // stages 8-10: isometric projection
   assign dif_in = iso_en ? x2 - y2 : x2;
   assign sum_in = iso_en ? x2 + y2 : y2;
   assign pd_in  = dif_ff * iso_trig_ff.cs;
   assign ps_in  = sum_ff * iso_trig_ff.sn;
   assign z2_sel = iso_en ? z2_s9_ff : '0;
   assign qx_in  = $signed(pd_ff[TRIG_FRAC_BITS +: COORD_W]);
   assign qy_in  = $signed(ps_ff[TRIG_FRAC_BITS +: COORD_W]) - z2_sel;

   // stage 11: floor to pixels, shift, saturate
   assign scr_x_in = to_screen((qx_ff >>> Q8_BITS) + COORD_W'(shift_x_ff));
   assign scr_y_in = to_screen((qy_ff >>> Q8_BITS) + COORD_W'(shift_y_ff));

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         px_ff <= px_in;
         py_ff <= py_in;
         ph_ff <= ph_in;
      end
      if (adv[1]) begin
         xb_ff <= xb_in;
         yb_ff <= yb_in;
         hz_ff <= hz_in;
      end
      if (adv[2]) begin
         xb_s2_ff <= xb_ff;
      end
      if (adv[3]) begin
         xb_s3_ff <= xb_s2_ff;
      end
      if (adv[4]) begin
         y1_s4_ff <= y1;
      end
      if (adv[5]) begin
         y1_s5_ff <= y1_s4_ff;
      end
      if (adv[6]) begin
         z2_s6_ff <= z2;
      end
      if (adv[7]) begin
         z2_s7_ff <= z2_s6_ff;
      end
      if (adv[8]) begin
         dif_ff   <= dif_in;
         sum_ff   <= sum_in;
         z2_s8_ff <= z2_s7_ff;
      end
      if (adv[9]) begin
         pd_ff    <= pd_in;
         ps_ff    <= ps_in;
         z2_s9_ff <= z2_s8_ff;
      end
      if (adv[10]) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
      end
      if (adv[11]) begin
         scr_x_ff <= scr_x_in;
         scr_y_ff <= scr_y_in;
      end
   end

   assign rsp_bus.valid    = vld_ff[NUM_STAGES-1];
   assign rsp_bus.screen_x = scr_x_ff;
   assign rsp_bus.screen_y = scr_y_ff;

endmodule

### hw/rtl/prp3d_checker.sv
// port level checks of the point rotate and project unit, bound to the top level
module prp3d_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [prp3d_pkg::SCREEN_W-1:0] rsp_screen_x,
   input logic signed [prp3d_pkg::SCREEN_W-1:0] rsp_screen_y,
   input logic                                  csr_valid
);
   import prp3d_pkg::*;

   logic [STAGE_W-1:0] fill_ff, fill_in;
   logic               req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // items inside the unit
   always_comb begin
      fill_in = fill_ff;
      if (req_take && !rsp_take) begin
         fill_in = fill_ff + STAGE_W'(1);
      end else if (!req_take && rsp_take) begin
         fill_in = fill_ff - STAGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x) && $stable(rsp_screen_y))
      else $error("rsp item changed or dropped while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fill_ff != '0)
      else $error("rsp item shown with no item inside");

   a_no_bypass: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 && req_take |=> !rsp_valid)
      else $error("rsp item one cycle after entering an empty unit");

   a_csr_first: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> !req_ready)
      else $error("req taken while a register write is presented");

   a_room: assert property (@(posedge clock) disable iff (reset)
      fill_ff < STAGE_W'(NUM_STAGES) && !csr_valid |-> req_ready)
      else $error("req refused while a stage is free");

endmodule

bind point_rotate_project_3d_unit prp3d_checker u_prp3d_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_screen_x (rsp_bus.screen_x),
   .rsp_screen_y (rsp_bus.screen_y),
   .csr_valid    (csr_bus.valid)
);

### sim/point_rotate_project_3d_unit_tb.sv
// self-checking testbench of the point rotate and project unit
`timescale 1ns / 100ps

module point_rotate_project_3d_unit_tb;
   import prp3d_pkg::*;

   // run shape
   localparam int RESET_CYCLES     = 4;
   localparam int NUM_PHASES       = 12;
   localparam int RANDOM_PER_PHASE = 98;
   localparam int HOLD_PHASE       = 9;
   localparam int PAUSE_PHASE      = 10;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int PIPE_LATENCY     = 11;
   localparam int STALL_LIMIT      = 4000;
   localparam int REPORT_LIMIT     = 10;

   // fixed point constants of the predictor
   localparam int                SERIES_ORDER     = 7;
   localparam longint unsigned   QUARTER_TURN_Q30 = 64'd1686629713;
   localparam longint            PIXEL_MAX        = (64'sd1 <<< (SCREEN_W - 1)) - 1;
   localparam longint            PIXEL_MIN        = -(64'sd1 <<< (SCREEN_W - 1));
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 4'd8;

   // register values after reset
   localparam logic [FIELD_W-1:0] ZOOM_DEFAULT    = 16'd256;
   localparam logic [FIELD_W-1:0] HSCALE_DEFAULT  = 16'd256;
   localparam logic [ISO_W-1:0]   ISO_DEFAULT     = 11'd1536;

   typedef struct packed {
      logic signed [FIELD_W-1:0] grid_x;
      logic signed [FIELD_W-1:0] grid_y;
      logic signed [FIELD_W-1:0] height;
   } point_type;

   typedef struct packed {
      logic signed [SCREEN_W-1:0] screen_x;
      logic signed [SCREEN_W-1:0] screen_y;
   } screen_pos_type;

   // our own copy of the setup registers, updated on each accepted write
   typedef struct {
      logic [FIELD_W-1:0]         zoom;
      logic signed [FIELD_W-1:0]  height_scale;
      logic signed [FIELD_W-1:0]  center_x;
      logic signed [FIELD_W-1:0]  center_y;
      logic [ROT_W-1:0]           angles;
      logic [ISO_W-1:0]           iso;
      logic signed [SCREEN_W-1:0] shift_x;
      logic signed [SCREEN_W-1:0] shift_y;
   } unit_regs_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   prp3d_csr_if csr_bus ();
   prp3d_req_if req_bus ();
   prp3d_rsp_if rsp_bus ();

   point_rotate_project_3d_unit dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   unit_regs_type  unit_regs;
   point_type      point_queue [$];     // items waiting for the driver
   screen_pos_type screen_expected [$]; // predicted screen positions, oldest first

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   // long receiver hold: requested by the sequence, timed by its own process
   logic long_hold_req   = 1'b0;
   logic long_hold_done  = 1'b0;
   int   long_hold_count = 0;

   int mismatch_count  = 0;
   int points_sent     = 0;
   int screens_checked = 0;
   int saturated_count = 0;
   int csr_writes      = 0;
   int settings_count  = 0;
   int quiet_cycles    = 0;

   // corner points: field extremes and sign boundaries
   point_type corner_points [8] = '{
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      '{16'sh8000, 16'sh8000, 16'sh8000},
      '{16'sh7FFF, 16'sh8000, 16'sd1},
      '{16'sh8000, 16'sh7FFF, -16'sd1},
      '{-16'sd1, -16'sd1, -16'sd1},
      '{16'sd1, 16'sd0, 16'sh8000},
      '{16'sd0, -16'sd1, 16'sh7FFF}
   };

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   function automatic void note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("error at %0t: %s", $realtime, what);
      end
   endfunction

   function automatic void load_reg_defaults();
      unit_regs.zoom         = ZOOM_DEFAULT;
      unit_regs.height_scale = HSCALE_DEFAULT;
      unit_regs.center_x     = '0;
      unit_regs.center_y     = '0;
      unit_regs.angles       = '0;
      unit_regs.iso          = ISO_DEFAULT;
      unit_regs.shift_x      = '0;
      unit_regs.shift_y      = '0;
   endfunction

   // bits above each register's width fall away, unknown indexes do nothing
   function automatic void apply_reg_write(input logic [CSR_INDEX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_ZOOM_FACTOR:     unit_regs.zoom         = value[FIELD_W-1:0];
         CSR_HEIGHT_SCALE:    unit_regs.height_scale = value[FIELD_W-1:0];
         CSR_CENTER_X:        unit_regs.center_x     = value[FIELD_W-1:0];
         CSR_CENTER_Y:        unit_regs.center_y     = value[FIELD_W-1:0];
         CSR_ROTATION_ANGLES: unit_regs.angles       = value[ROT_W-1:0];
         CSR_ISO_CONTROL:     unit_regs.iso          = value[ISO_W-1:0];
         CSR_SHIFT_X:         unit_regs.shift_x      = value[SCREEN_W-1:0];
         CSR_SHIFT_Y:         unit_regs.shift_y      = value[SCREEN_W-1:0];
         default: ;
      endcase
   endfunction

   // q30 taylor series of sin or cos on [0, pi/2), each term floored
   function automatic longint taylor_q30(input longint unsigned r, input bit cosine);
      longint unsigned sq;
      longint unsigned term;
      longint          acc;
      int              n;
      sq   = (r * r) >> 30;
      term = cosine ? (64'd1 << 30) : r;
      acc  = longint'(term);
      for (n = 1; n <= SERIES_ORDER; n++) begin
         term = (term * sq) >> 30;
         term = cosine ? term / longint'((2 * n - 1) * (2 * n))
                       : term / longint'((2 * n) * (2 * n + 1));
         acc  = n[0] ? acc - longint'(term) : acc + longint'(term);
      end
      return acc;
   endfunction

   // clamp to [0, 1] and round half up to the trig fraction
   function automatic longint trig_round(input longint v);
      longint c;
      c = (v < 0) ? 64'sd0 : v;
      if (c > (64'sd1 <<< 30)) begin
         c = 64'sd1 <<< 30;
      end
      return (c + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
   endfunction

   function automatic void angle_trig(input logic [ANGLE_BITS-1:0] code,
                                      output longint sn, output longint cs);
      longint unsigned turn4;
      longint unsigned quad;
      longint unsigned rem;
      longint unsigned r;
      longint          s;
      longint          c;
      turn4 = 64'd4 * code;
      quad  = turn4 / ANGLE_STEPS;
      rem   = turn4 - quad * ANGLE_STEPS;
      r     = QUARTER_TURN_Q30 * rem / ANGLE_STEPS;
      s     = trig_round(taylor_q30(r, 1'b0));
      c     = trig_round(taylor_q30(r, 1'b1));
      // fold the first quadrant value out to the full turn
      case (quad[1:0])
         2'd0: begin sn = s;  cs = c;  end
         2'd1: begin sn = c;  cs = -s; end
         2'd2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   // add the screen shift, floor to pixels and saturate
   function automatic logic signed [SCREEN_W-1:0] to_pixel(input longint q8,
                                                           input longint shift);
      longint v;
      v = (q8 + shift * 256) >>> Q8_BITS;
      if (v > PIXEL_MAX) begin
         v = PIXEL_MAX;
      end
      if (v < PIXEL_MIN) begin
         v = PIXEL_MIN;
      end
      return SCREEN_W'(v);
   endfunction

   function automatic screen_pos_type project_point(input point_type p);
      longint gx, gy, gh, zoom, hs, xb, yb, zs;
      longint y1, z1, x1, z2, x2, y2, px, py;
      longint sin_x, cos_x, sin_y, cos_y, sin_z, cos_z, sin_i, cos_i;
      screen_pos_type pos;
      gx   = longint'(p.grid_x);
      gy   = longint'(p.grid_y);
      gh   = longint'(p.height);
      zoom = longint'(unit_regs.zoom);
      hs   = longint'(unit_regs.height_scale);
      angle_trig(unit_regs.angles[ANGLE_BITS-1:0], sin_x, cos_x);
      angle_trig(unit_regs.angles[2*ANGLE_BITS-1:ANGLE_BITS], sin_y, cos_y);
      angle_trig(unit_regs.angles[3*ANGLE_BITS-1:2*ANGLE_BITS], sin_z, cos_z);

      // scale and center in q.8, height gets the extra scale
      xb = gx * zoom - longint'(unit_regs.center_x) * 256;
      yb = gy * zoom - longint'(unit_regs.center_y) * 256;
      zs = (gh * zoom * hs) >>> Q8_BITS;

      // rotate about x, then y, then z
      y1 = (yb * cos_x - zs * sin_x) >>> TRIG_FRAC_BITS;
      z1 = (yb * sin_x + zs * cos_x) >>> TRIG_FRAC_BITS;
      x1 = (xb * cos_y - z1 * sin_y) >>> TRIG_FRAC_BITS;
      z2 = (xb * sin_y + z1 * cos_y) >>> TRIG_FRAC_BITS;
      x2 = (x1 * cos_z - y1 * sin_z) >>> TRIG_FRAC_BITS;
      y2 = (x1 * sin_z + y1 * cos_z) >>> TRIG_FRAC_BITS;

      // optional isometric projection, the angle is a don't care when off
      if (unit_regs.iso[ISO_EN_BIT]) begin
         angle_trig(unit_regs.iso[ANGLE_BITS-1:0], sin_i, cos_i);
         px = x2;
         py = y2;
         x2 = ((px - py) * cos_i) >>> TRIG_FRAC_BITS;
         y2 = ((px + py) * sin_i - z2 * (64'sd1 <<< TRIG_FRAC_BITS)) >>> TRIG_FRAC_BITS;
      end

      pos.screen_x = to_pixel(x2, longint'(unit_regs.shift_x));
      pos.screen_y = to_pixel(y2, longint'(unit_regs.shift_y));
      return pos;
   endfunction

   // ---------------------------------------------------------------------
   // point driver: one item per handshake, random gaps from req_idle_pct
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : point_driver
      point_type next_pt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         // predict on acceptance, with the registers as they stand now
         if (req_bus.valid && req_bus.ready) begin
            screen_expected.push_back(project_point({req_bus.grid_x, req_bus.grid_y,
                                                     req_bus.height}));
            points_sent++;
         end
         // an offered item stays on the bus until it is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (point_queue.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               next_pt = point_queue.pop_front();
               req_bus.grid_x <= next_pt.grid_x;
               req_bus.grid_y <= next_pt.grid_y;
               req_bus.height <= next_pt.height;
               req_bus.valid  <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // screen monitor: compare each item against the oldest prediction
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : screen_monitor
      screen_pos_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (screen_expected.size() == 0) begin
               note_failure($sformatf("screen item x=%0d y=%0d with nothing expected",
                                      rsp_bus.screen_x, rsp_bus.screen_y));
            end else begin
               want = screen_expected.pop_front();
               if (rsp_bus.screen_x !== want.screen_x) begin
                  note_failure($sformatf("screen_x expected %0d, got %0d",
                                         want.screen_x, rsp_bus.screen_x));
               end
               if (rsp_bus.screen_y !== want.screen_y) begin
                  note_failure($sformatf("screen_y expected %0d, got %0d",
                                         want.screen_y, rsp_bus.screen_y));
               end
               if (want.screen_x == SCREEN_W'(PIXEL_MAX) || want.screen_x == SCREEN_W'(PIXEL_MIN)
                   || want.screen_y == SCREEN_W'(PIXEL_MAX)
                   || want.screen_y == SCREEN_W'(PIXEL_MIN)) begin
                  saturated_count++;
               end
               screens_checked++;
            end
         end
         rsp_bus.ready <= !(long_hold_req && !long_hold_done)
                          && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // long receiver hold, long enough to fill every pipeline stage
   always @(posedge clock) begin
      if (long_hold_req && !long_hold_done) begin
         long_hold_count <= long_hold_count + 1;
         if (long_hold_count == LONG_HOLD_CYCLES - 1) begin
            long_hold_done <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: cycles in a row with no handshake on any channel
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
      end
      $display("timeout: no handshake for %0d cycles, %0d items still expected",
               STALL_LIMIT, screen_expected.size());
      $display("point_rotate_project_3d_unit_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // sequence helpers
   // ---------------------------------------------------------------------

   // register write; valid is left high so writes can go back to back
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      apply_reg_write(idx, value);
      csr_writes++;
   endtask

   // nothing queued, nothing on the bus, nothing in the pipe
   task automatic wait_unit_idle();
      while (point_queue.size() != 0 || req_bus.valid || screen_expected.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // half full range, half small values that keep high zoom off the rails
   function automatic point_type random_point();
      point_type p;
      if ($urandom_range(1)) begin
         p.grid_x = $urandom();
         p.grid_y = $urandom();
         p.height = $urandom();
      end else begin
         p.grid_x = $urandom_range(0, 255) - 128;
         p.grid_y = $urandom_range(0, 255) - 128;
         p.height = $urandom_range(0, 255) - 128;
      end
      return p;
   endfunction

   // random register data with junk above the field, sometimes a small value
   function automatic logic [CSR_DATA_W-1:0] junk_small(input int lo_bits, input int span);
      logic [CSR_DATA_W-1:0] value;
      value = $urandom();
      if ($urandom_range(1)) begin
         value = (value >> lo_bits) << lo_bits;
         value = value | (CSR_DATA_W'($urandom_range(0, 2 * span) - span)
                          & ((32'd1 << lo_bits) - 1));
      end
      return value;
   endfunction

   task automatic load_phase_setup(input int ph);
      case (ph)
         0: begin
            // reset values stay, a write past the register list must not land
            write_reg(CSR_SPARE_FIRST + 4'($urandom_range(0, 7)), $urandom());
         end
         1: begin
            // every register at its top value
            write_reg(CSR_ZOOM_FACTOR, 32'hFFFF);
            write_reg(CSR_HEIGHT_SCALE, 32'h7FFF);
            write_reg(CSR_CENTER_X, 32'h7FFF);
            write_reg(CSR_CENTER_Y, 32'h7FFF);
            write_reg(CSR_ROTATION_ANGLES, 32'h3FFF_FFFF);
            write_reg(CSR_ISO_CONTROL, 32'h7FF);
            write_reg(CSR_SHIFT_X, 32'h7F_FFFF);
            write_reg(CSR_SHIFT_Y, 32'h7F_FFFF);
         end
         2: begin
            // every register at its bottom value, iso off
            write_reg(CSR_ZOOM_FACTOR, 32'h0);
            write_reg(CSR_HEIGHT_SCALE, 32'h8000);
            write_reg(CSR_CENTER_X, 32'h8000);
            write_reg(CSR_CENTER_Y, 32'h8000);
            write_reg(CSR_ROTATION_ANGLES, 32'h0);
            write_reg(CSR_ISO_CONTROL, 32'h0);
            write_reg(CSR_SHIFT_X, 32'h80_0000);
            write_reg(CSR_SHIFT_Y, 32'h80_0000);
         end
         3: begin
            // quarter turn boundaries on each axis, iso off with a live angle
            write_reg(CSR_ZOOM_FACTOR, 32'd256);
            write_reg(CSR_HEIGHT_SCALE, 32'd256);
            write_reg(CSR_CENTER_X, 32'd100);
            write_reg(CSR_CENTER_Y, -32'sd100);
            write_reg(CSR_ROTATION_ANGLES, (32'd768 << 20) | (32'd512 << 10) | 32'd256);
            write_reg(CSR_ISO_CONTROL, 32'd300);
            write_reg(CSR_SHIFT_X, 32'd1000);
            write_reg(CSR_SHIFT_Y, -32'sd1000);
         end
         default: begin
            write_reg(CSR_ZOOM_FACTOR, junk_small(FIELD_W, 600) + 32'd600);
            write_reg(CSR_HEIGHT_SCALE, junk_small(FIELD_W, 1024));
            write_reg(CSR_CENTER_X, junk_small(FIELD_W, 200));
            write_reg(CSR_CENTER_Y, junk_small(FIELD_W, 200));
            write_reg(CSR_ROTATION_ANGLES, $urandom());
            write_reg(CSR_ISO_CONTROL, $urandom());
            write_reg(CSR_SHIFT_X, junk_small(SCREEN_W, 4096));
            write_reg(CSR_SHIFT_Y, junk_small(SCREEN_W, 4096));
            write_reg(CSR_SPARE_FIRST + 4'($urandom_range(0, 7)), $urandom());
         end
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      int ph;
      int n;
      req_bus.valid  = 1'b0;
      req_bus.grid_x = '0;
      req_bus.grid_y = '0;
      req_bus.height = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      load_reg_defaults();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_unit_idle();
         repeat (2) @(posedge clock);

         // idling: slow receiver first, then slow sender, then full rate
         if (ph < 4) begin
            req_idle_pct  = 28;
            rsp_stall_pct = 76;
         end else if (ph < 8) begin
            req_idle_pct  = 76;
            rsp_stall_pct = 28;
         end else begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end

         load_phase_setup(ph);
         settings_count++;

         // field extremes under the reset, top and bottom settings
         if (ph < 3) begin
            foreach (corner_points[i]) point_queue.push_back(corner_points[i]);
         end

         // receiver stops while the sender keeps offering: the pipe backs up
         if (ph == HOLD_PHASE) begin
            long_hold_req = 1'b1;
         end

         if (ph == PAUSE_PHASE) begin
            // sender goes quiet until the pipe has fully drained
            for (n = 0; n < RANDOM_PER_PHASE / 2; n++) point_queue.push_back(random_point());
            wait_unit_idle();
            for (n = RANDOM_PER_PHASE / 2; n < RANDOM_PER_PHASE; n++) begin
               point_queue.push_back(random_point());
            end
         end else begin
            for (n = 0; n < RANDOM_PER_PHASE; n++) point_queue.push_back(random_point());
         end
      end

      wait_unit_idle();
      repeat (2 * PIPE_LATENCY + 4) @(posedge clock);

      if (screen_expected.size() != 0) begin
         note_failure($sformatf("%0d screen items never arrived", screen_expected.size()));
      end

      $display("ran %0d points through %0d register settings (%0d writes incl. spare indexes)",
               points_sent, settings_count, csr_writes);
      $display("checked %0d screen items, %0d with a saturated field, %0d mismatches",
               screens_checked, saturated_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("point_rotate_project_3d_unit_tb: PASS");
      end else begin
         $display("point_rotate_project_3d_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

### point_rotate_project_3d_unit.f
hw/rtl/prp3d_pkg.sv
hw/rtl/prp3d_if.sv
hw/rtl/prp3d_trig.sv
hw/rtl/prp3d_rot.sv
hw/rtl/point_rotate_project_3d_unit.sv
hw/rtl/prp3d_checker.sv
sim/point_rotate_project_3d_unit_tb.sv
